// ===== hw/rtl/keystroke_line_edit_buffer_assert.svh =====
// Assertion macros for the keystroke line edit buffer.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef KEYSTROKE_LINE_EDIT_BUFFER_ASSERT_SVH
`define KEYSTROKE_LINE_EDIT_BUFFER_ASSERT_SVH

// Same-cycle implication, skipped while reset is high.
`define KLED_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, skipped while reset is high.
`define KLED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/kled_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the
// keystroke line edit buffer. No dependencies.
`default_nettype none

package kled_pkg;

  localparam int DEF_MAX_CHARS   = 127;
  localparam int DEF_STORE_DEPTH = 128;

  // Key bytes with a meaning of their own
  localparam logic [7:0] KEY_ENTER   = 8'd10;
  localparam logic [7:0] KEY_ABORT   = 8'd3;
  localparam logic [7:0] KEY_DEL     = 8'd127;
  localparam logic [7:0] KEY_ESC     = 8'd27;
  localparam logic [7:0] KEY_BRACKET = 8'h5B;  // '['
  localparam logic [7:0] KEY_LEFT    = 8'h44;  // 'D'
  localparam logic [7:0] KEY_RIGHT   = 8'h43;  // 'C'
  localparam logic [7:0] PRINT_LO    = 8'h20;
  localparam logic [7:0] PRINT_HI    = 8'h7E;

  // Operation selector
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Reported key effect
  localparam logic [2:0] EFF_IGNORED  = 3'd0;
  localparam logic [2:0] EFF_INSERTED = 3'd1;
  localparam logic [2:0] EFF_DELETED  = 3'd2;
  localparam logic [2:0] EFF_MOVED    = 3'd3;
  localparam logic [2:0] EFF_ESCAPE   = 3'd4;
  localparam logic [2:0] EFF_FINISHED = 3'd5;

  // Escape sequence phase
  localparam logic [1:0] ESC_NORMAL  = 2'd0;
  localparam logic [1:0] ESC_FIRST   = 2'd1;
  localparam logic [1:0] ESC_BRACKET = 2'd2;
  localparam logic [1:0] ESC_OTHER   = 2'd3;

  // Line state
  localparam logic [1:0] FIN_EDIT    = 2'd0;
  localparam logic [1:0] FIN_DONE    = 2'd1;
  localparam logic [1:0] FIN_ABORTED = 2'd2;

  // Kind of work a decoded item needs
  localparam logic [1:0] KIND_SIMPLE = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_INSERT = 2'd2;
  localparam logic [1:0] KIND_DELETE = 2'd3;

  typedef struct packed {
    logic load;     // capture the input transfer
    logic decode;   // classify item, apply simple updates, set up the shift
    logic move;     // copy one store entry
    logic commit;   // finish an insert or delete
    logic publish;  // load the output register
  } kled_cmd_t;

  typedef struct packed {
    logic [1:0] kind;       // valid during decode
    logic       move_zero;  // nothing to shift, valid during decode
    logic       move_last;  // last entry of the shift
    logic       out_free;   // output register can take a result
  } kled_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/kled_ctrl.sv =====
// Sequencer for the keystroke line edit buffer.
// Depends on kled_pkg; drives the datapath through kled_cmd_t.
`default_nettype none

module kled_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  kled_pkg::kled_status_t status,
  output kled_pkg::kled_cmd_t    cmd
);
  import kled_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_DECODE  = 3'd1;
  localparam logic [2:0] ST_MOVE    = 3'd2;
  localparam logic [2:0] ST_DRAIN   = 3'd3;
  localparam logic [2:0] ST_COMMIT  = 3'd4;
  localparam logic [2:0] ST_PUBLISH = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    in_ready    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        if (status.kind == KIND_INSERT || status.kind == KIND_DELETE) begin
          state_next = status.move_zero ? ST_COMMIT : ST_MOVE;
        end else begin
          state_next = ST_PUBLISH;
        end
      end
      ST_MOVE: begin
        cmd.move = 1'b1;
        if (status.move_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last copied entry is written back this cycle
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_PUBLISH;
      end
      ST_PUBLISH: begin
        if (status.out_free) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/kled_dp.sv =====
// Datapath of the keystroke line edit buffer: line store, cursor and length,
// escape and line state, shift pointers and output register. Depends on kled_pkg.
`default_nettype none

`include "keystroke_line_edit_buffer_assert.svh"

module kled_dp #(
  parameter int MAX_CHARS   = kled_pkg::DEF_MAX_CHARS,
  parameter int STORE_DEPTH = kled_pkg::DEF_STORE_DEPTH
) (
  input  wire                   clk,
  input  wire                   rst,
  input  kled_pkg::kled_cmd_t    cmd,
  output kled_pkg::kled_status_t status,
  input  wire                   in_op,
  input  wire  [7:0]            in_key,
  input  wire  [6:0]            in_read_index,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [31:0]           out_data
);
  import kled_pkg::*;

  localparam int LEN_W = $clog2(STORE_DEPTH + 1);
  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int IW    = (LEN_W > 7) ? LEN_W : 7;
  localparam int LIMIT = (MAX_CHARS < STORE_DEPTH) ? MAX_CHARS : STORE_DEPTH;
  localparam logic [LEN_W-1:0] LIMIT_L = LEN_W'(LIMIT);

  logic [7:0]       line_store [STORE_DEPTH];

  logic             op_q;
  logic [7:0]       key_q;
  logic [6:0]       ridx_q;
  logic [LEN_W-1:0] length;
  logic [LEN_W-1:0] cursor;
  logic [1:0]       esc;
  logic [1:0]       fin;
  logic [1:0]       kind_q;
  logic [2:0]       eff_q;
  logic [AW-1:0]    mv_src;
  logic [LEN_W-1:0] mv_cnt;
  logic [AW-1:0]    dst_q;
  logic             pend;
  logic [7:0]       rdata;

  // decode results
  logic [1:0]       dec_kind;
  logic [2:0]       dec_eff;
  logic [1:0]       dec_esc;
  logic [1:0]       dec_fin;
  logic [LEN_W-1:0] dec_cursor;

  logic [LEN_W-1:0] len_m1;
  logic [AW-1:0]    src_init;
  logic [IW-1:0]    ridx_ext;
  logic [IW-1:0]    len_ext;
  logic [IW-1:0]    cur_ext;
  logic             in_range;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [7:0]       wr_data;
  logic             is_insert_q;
  logic [7:0]       char_val;

  always_comb begin
    dec_kind   = KIND_SIMPLE;
    dec_eff    = EFF_IGNORED;
    dec_esc    = esc;
    dec_fin    = fin;
    dec_cursor = cursor;
    if (op_q == OP_READ) begin
      dec_kind = KIND_READ;
    end else if (fin != FIN_EDIT) begin
      dec_eff = EFF_IGNORED;
    end else if (esc == ESC_FIRST) begin
      dec_esc = (key_q == KEY_BRACKET) ? ESC_BRACKET : ESC_OTHER;
      dec_eff = EFF_ESCAPE;
    end else if (esc == ESC_BRACKET || esc == ESC_OTHER) begin
      dec_esc = ESC_NORMAL;
      if (esc == ESC_BRACKET && key_q == KEY_LEFT && cursor != '0) begin
        dec_cursor = cursor - LEN_W'(1);
        dec_eff    = EFF_MOVED;
      end else if (esc == ESC_BRACKET && key_q == KEY_RIGHT && cursor < length) begin
        dec_cursor = cursor + LEN_W'(1);
        dec_eff    = EFF_MOVED;
      end
    end else if (key_q == KEY_ENTER) begin
      dec_fin = FIN_DONE;
      dec_eff = EFF_FINISHED;
    end else if (key_q == KEY_ABORT) begin
      dec_fin = FIN_ABORTED;
      dec_eff = EFF_FINISHED;
    end else if (key_q == KEY_DEL) begin
      if (cursor != '0) begin
        dec_kind = KIND_DELETE;
        dec_eff  = EFF_DELETED;
      end
    end else if (key_q == KEY_ESC) begin
      dec_esc = ESC_FIRST;
      dec_eff = EFF_ESCAPE;
    end else if (key_q >= PRINT_LO && key_q <= PRINT_HI) begin
      if (length < LIMIT_L) begin
        dec_kind = KIND_INSERT;
        dec_eff  = EFF_INSERTED;
      end
    end
  end

  // Insert copies from the end of the line down to the cursor, one slot up;
  // delete copies from the cursor up to the end, one slot down.
  assign len_m1      = length - LEN_W'(1);
  assign src_init    = (dec_kind == KIND_INSERT) ? len_m1[AW-1:0] : cursor[AW-1:0];
  assign is_insert_q = (kind_q == KIND_INSERT);

  assign ridx_ext = IW'(ridx_q);
  assign len_ext  = IW'(length);
  assign cur_ext  = IW'(cursor);
  assign in_range = ridx_ext < len_ext;

  assign rd_addr = cmd.move ? mv_src : ridx_ext[AW-1:0];
  assign wr_en   = pend || (cmd.commit && is_insert_q);
  assign wr_addr = pend ? dst_q : cursor[AW-1:0];
  assign wr_data = pend ? rdata : key_q;

  assign status.kind      = dec_kind;
  assign status.move_zero = (length == cursor);
  assign status.move_last = (mv_cnt == LEN_W'(1));
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_store[wr_addr] <= wr_data;
    end
    rdata <= line_store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= in_op;
      key_q  <= in_key;
      ridx_q <= in_read_index;
    end
    if (cmd.decode) begin
      kind_q <= dec_kind;
      eff_q  <= dec_eff;
      mv_src <= src_init;
      mv_cnt <= length - cursor;
    end
    if (cmd.move) begin
      mv_src <= is_insert_q ? mv_src - AW'(1) : mv_src + AW'(1);
      dst_q  <= is_insert_q ? mv_src + AW'(1) : mv_src - AW'(1);
      mv_cnt <= mv_cnt - LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
      cursor <= '0;
      esc    <= ESC_NORMAL;
      fin    <= FIN_EDIT;
      pend   <= 1'b0;
    end else begin
      pend <= cmd.move;
      if (cmd.decode) begin
        esc    <= dec_esc;
        fin    <= dec_fin;
        cursor <= dec_cursor;
      end
      if (cmd.commit) begin
        if (is_insert_q) begin
          length <= length + LEN_W'(1);
          cursor <= cursor + LEN_W'(1);
        end else begin
          length <= length - LEN_W'(1);
          cursor <= cursor - LEN_W'(1);
        end
      end
    end
  end

  assign char_val = (op_q == OP_READ && in_range) ? rdata : 8'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_data <= {5'd0, eff_q, (fin == FIN_ABORTED), (fin == FIN_DONE),
                   cur_ext[6:0], len_ext[6:0], char_val};
    end
  end

  `KLED_ASSERT_NOW(a_cursor_in_line, 1'b1, cursor <= length, "cursor beyond line end")
  `KLED_ASSERT_NOW(a_length_limit, 1'b1, length <= LIMIT_L, "length above limit")
  `KLED_ASSERT_NEXT(a_fin_sticky, fin != FIN_EDIT, fin == $past(fin), "line state left finished")
  `KLED_ASSERT_NOW(a_move_count, cmd.move, mv_cnt != '0, "shift step with nothing left")
  `KLED_ASSERT_NOW(a_write_one_source, pend, !cmd.commit, "shift write collides with commit")

endmodule

`default_nettype wire

// ===== hw/rtl/keystroke_line_edit_buffer.sv =====
// Keystroke line edit buffer: a line store with a cursor, edited one key per transfer.
// A read, or a key that moves no characters, is captured, decoded and then loaded into the
// output register; an insert or delete at the line end passes a commit step on the way. An
// insert or delete that moves n = length - cursor characters shifts them before its commit,
// because the line store's single write port moves one character per cycle. The load into
// the output register waits on m_tready while that register holds an unaccepted result.
// The input takes a new transfer once the previous item sits in the output register, in
// the next cycle at the earliest. The line store needs no clearing pass: entries at or past
// the length always read as zero. s_tuser selects keystroke (0) or character read (1).
// Top level; depends on kled_pkg, kled_ctrl and kled_dp.
`default_nettype none

module keystroke_line_edit_buffer #(
  parameter int MAX_CHARS   = kled_pkg::DEF_MAX_CHARS,
  parameter int STORE_DEPTH = kled_pkg::DEF_STORE_DEPTH
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [15:0] s_tdata,   // key [7:0], read_index [14:8], zero [15]
  input  wire         s_tuser,   // op
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [31:0] m_tdata    // char_out [7:0], text_length [14:8], cursor_at [21:15],
                                 // line_done [22], aborted [23], key_effect [26:24],
                                 // zero [31:27]
);
  import kled_pkg::*;

  kled_cmd_t    cmd;
  kled_status_t status;

  kled_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  kled_dp #(
    .MAX_CHARS   (MAX_CHARS),
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .in_op         (s_tuser),
    .in_key        (s_tdata[7:0]),
    .in_read_index (s_tdata[14:8]),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_data      (m_tdata)
  );

endmodule

`default_nettype wire

// ===== sim/keystroke_line_edit_buffer_tb.sv =====
// Self-checking testbench for keystroke_line_edit_buffer: a queue-fed stream driver,
// an in-order result monitor and a line editor predictor in SystemVerilog.
// Depends on kled_pkg and the RTL of the block.
`timescale 1ns / 1ps

module keystroke_line_edit_buffer_tb;
  import kled_pkg::*;

  localparam int LINE_LIMIT = (DEF_MAX_CHARS < DEF_STORE_DEPTH) ? DEF_MAX_CHARS
                                                                  : DEF_STORE_DEPTH;
  localparam int SETTLE_CYCLES = DEF_STORE_DEPTH + 12;

  typedef struct packed {
    logic       op;
    logic [7:0] key;
    logic [6:0] ridx;
    logic       drain;  // hold off until all results are back
    logic       calm;   // no idling on either side
  } key_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic [6:0] text_length;
    logic [6:0] cursor_at;
    logic       line_done;
    logic       aborted;
    logic [2:0] key_effect;
  } line_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  keystroke_line_edit_buffer DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Predicted editor state
  logic [7:0] line_chars [DEF_STORE_DEPTH];
  logic [6:0] line_len = '0;
  logic [6:0] cursor_pos = '0;
  logic [1:0] esc_state = ESC_NORMAL;
  logic [1:0] fin_state = FIN_EDIT;

  key_item_t    item_q [$];
  line_result_t expected_q [$];
  key_item_t    cur_item;
  logic         drain_next = 1'b0;
  logic         calm_fill = 1'b0;
  logic         calm_now = 1'b0;
  int           gap_left = 0;
  int           stall_left = 0;
  int           mismatch_count = 0;
  int           transfers_in = 0;
  int           results_seen = 0;
  int           peak_len = 0;
  int           effect_hits [8];
  logic [7:0]   ending_key;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Timeout: %0d of %0d results arrived", results_seen, transfers_in);
    $display("Mismatches found");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("MISMATCH result %0d: %s got %0d expected %0d", results_seen, what, got, want);
  endtask

  // Applies one accepted transfer to the predicted state, returns the expected result.
  function automatic line_result_t apply_item(input key_item_t it);
    line_result_t r;
    int i;
    r = '0;
    r.key_effect = EFF_IGNORED;
    if (it.op == OP_READ) begin
      if (it.ridx < line_len) r.char_out = line_chars[it.ridx];
    end else if (fin_state != FIN_EDIT) begin
      r.key_effect = EFF_IGNORED;
    end else if (esc_state == ESC_FIRST) begin
      esc_state = (it.key == KEY_BRACKET) ? ESC_BRACKET : ESC_OTHER;
      r.key_effect = EFF_ESCAPE;
    end else if (esc_state != ESC_NORMAL) begin
      // second byte after ESC is always consumed
      if (esc_state == ESC_BRACKET && it.key == KEY_LEFT && cursor_pos > 0) begin
        cursor_pos--;
        r.key_effect = EFF_MOVED;
      end else if (esc_state == ESC_BRACKET && it.key == KEY_RIGHT &&
                   cursor_pos < line_len) begin
        cursor_pos++;
        r.key_effect = EFF_MOVED;
      end
      esc_state = ESC_NORMAL;
    end else if (it.key == KEY_ENTER) begin
      fin_state = FIN_DONE;
      r.key_effect = EFF_FINISHED;
    end else if (it.key == KEY_ABORT) begin
      fin_state = FIN_ABORTED;
      r.key_effect = EFF_FINISHED;
    end else if (it.key == KEY_DEL) begin
      if (cursor_pos != 0) begin
        for (i = cursor_pos - 1; i + 1 < line_len; i++) line_chars[i] = line_chars[i + 1];
        cursor_pos--;
        line_len--;
        line_chars[line_len] = '0;
        r.key_effect = EFF_DELETED;
      end
    end else if (it.key == KEY_ESC) begin
      esc_state = ESC_FIRST;
      r.key_effect = EFF_ESCAPE;
    end else if (it.key >= PRINT_LO && it.key <= PRINT_HI) begin
      if (line_len < LINE_LIMIT) begin
        for (i = line_len; i > cursor_pos; i--) line_chars[i] = line_chars[i - 1];
        line_chars[cursor_pos] = it.key;
        line_len++;
        cursor_pos++;
        r.key_effect = EFF_INSERTED;
      end
    end
    r.text_length = line_len;
    r.cursor_at   = cursor_pos;
    r.line_done   = (fin_state == FIN_DONE);
    r.aborted     = (fin_state == FIN_ABORTED);
    if (it.op == OP_KEY) effect_hits[r.key_effect]++;
    if (line_len > peak_len) peak_len = line_len;
    return r;
  endfunction

  task automatic queue_item(input logic op, input logic [7:0] key, input logic [6:0] idx);
    key_item_t it;
    it.op    = op;
    it.key   = key;
    it.ridx  = idx;
    it.drain = drain_next;
    it.calm  = calm_fill;
    drain_next = 1'b0;
    item_q.push_back(it);
  endtask

  task automatic key_press(input logic [7:0] key);
    queue_item(OP_KEY, key, 7'($urandom_range(0, 127)));
  endtask

  task automatic read_at(input logic [6:0] idx);
    queue_item(OP_READ, 8'($urandom_range(0, 255)), idx);
  endtask

  // One editing action: an insert, a delete, a whole escape sequence, a broken one, noise or a read.
  task automatic random_action(input int ins_pct, input int del_pct, input int esc_pct);
    int pick;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < ins_pct) begin
      key_press(8'($urandom_range(PRINT_LO, PRINT_HI)));
    end else if (pick < ins_pct + del_pct) begin
      key_press(KEY_DEL);
    end else if (pick < ins_pct + del_pct + esc_pct) begin
      key_press(KEY_ESC);
      key_press(KEY_BRACKET);
      key_press(($urandom_range(0, 9) < 7) ? KEY_LEFT : KEY_RIGHT);
    end else if (pick < ins_pct + del_pct + esc_pct + 3) begin
      key_press(KEY_ESC);
      key_press(($urandom_range(0, 1) == 0) ? KEY_BRACKET : 8'($urandom_range(0, 255)));
      key_press(8'($urandom_range(0, 255)));
    end else if (pick < ins_pct + del_pct + esc_pct + 6) begin
      b = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(128, 255))
                                      : 8'($urandom_range(0, 31));
      if (b == KEY_ENTER || b == KEY_ABORT || b == KEY_ESC) b = b | 8'h80;
      key_press(b);
    end else begin
      read_at(($urandom_range(0, 1) == 0) ? 7'($urandom_range(0, 127))
                                          : 7'($urandom_range(0, 15)));
    end
  endtask

  // Driver: one transfer at a time from item_q, prediction at acceptance
  always @(posedge clk) begin : drive_proc
    logic take;
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_q.push_back(apply_item(cur_item));
        transfers_in++;
      end
      if (!s_tvalid || s_tready) begin
        take = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (item_q.size() > 0) begin
          if (item_q[0].drain && expected_q.size() > 0) begin
            take = 1'b0;
          end else if (!item_q[0].calm && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(0, 12);
          end else begin
            take = 1'b1;
          end
        end
        if (take) begin
          cur_item = item_q.pop_front();
          s_tdata  <= {1'b0, cur_item.ridx, cur_item.key};
          s_tuser  <= cur_item.op;
          calm_now <= cur_item.calm;
        end
        s_tvalid <= take;
      end
    end
  end

  // Monitor: in-order compare against the oldest expectation
  always @(posedge clk) begin : watch_proc
    line_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing pending, m_tdata", m_tdata, 0);
        end else begin
          want = expected_q.pop_front();
          if (m_tdata[7:0] != want.char_out)
            report_mismatch("char_out", m_tdata[7:0], want.char_out);
          if (m_tdata[14:8] != want.text_length)
            report_mismatch("text_length", m_tdata[14:8], want.text_length);
          if (m_tdata[21:15] != want.cursor_at)
            report_mismatch("cursor_at", m_tdata[21:15], want.cursor_at);
          if (m_tdata[22] != want.line_done)
            report_mismatch("line_done", m_tdata[22], want.line_done);
          if (m_tdata[23] != want.aborted)
            report_mismatch("aborted", m_tdata[23], want.aborted);
          if (m_tdata[26:24] != want.key_effect)
            report_mismatch("key_effect", m_tdata[26:24], want.key_effect);
          if (m_tdata[31:27] != '0)
            report_mismatch("pad bits", m_tdata[31:27], 0);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!calm_now && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 12);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [7:0] other_key;
    foreach (line_chars[i]) line_chars[i] = '0;
    foreach (effect_hits[i]) effect_hits[i] = 0;

    // Directed: empty line, edges of the printable range, moves, escape corner cases
    read_at(7'd127);
    key_press(KEY_DEL);                                   // delete with cursor at start
    key_press(KEY_ESC); key_press(KEY_BRACKET); key_press(KEY_LEFT);  // left at 0
    key_press(PRINT_LO);
    key_press(PRINT_HI);
    key_press("A");
    key_press(8'h1F);
    key_press(8'hFF);
    key_press(KEY_ESC); key_press(KEY_BRACKET); key_press(KEY_LEFT);
    key_press("m");                                       // insert mid-line
    key_press(KEY_DEL);                                   // delete mid-line
    key_press(KEY_ESC); key_press(KEY_BRACKET); key_press(KEY_RIGHT);
    key_press(KEY_ESC); key_press(KEY_BRACKET); key_press(KEY_RIGHT); // right at end
    key_press(KEY_ESC); key_press("x"); key_press(KEY_LEFT);          // swallowed pair
    key_press(KEY_ESC); key_press(KEY_ENTER); key_press(KEY_ABORT);   // eaten by escape
    read_at(7'd1);
    read_at(7'd3);                                        // past the end

    // Mixed editing, with a quiet window in the middle
    drain_next = 1'b1;
    while (item_q.size() < 160) begin
      calm_fill = (item_q.size() >= 90 && item_q.size() < 120);
      random_action(40, 15, 20);
    end
    // Mostly inserts, runs the line into its length limit
    calm_fill = 1'b0;
    drain_next = 1'b1;
    while (item_q.size() < 360) random_action(82, 3, 8);
    // Mostly deletes and moves, no idling in the last stretch
    drain_next = 1'b1;
    while (item_q.size() < 460) begin
      calm_fill = (item_q.size() >= 400);
      random_action(20, 40, 20);
    end

    // Finish the line one way; everything after it is ignored
    calm_fill  = 1'b1;
    ending_key = ($urandom_range(0, 1) == 0) ? KEY_ENTER : KEY_ABORT;
    other_key  = (ending_key == KEY_ENTER) ? KEY_ABORT : KEY_ENTER;
    key_press(ending_key);
    key_press(other_key);
    key_press("Z");
    key_press(KEY_DEL);
    key_press(KEY_ESC); key_press(KEY_BRACKET); key_press(KEY_LEFT);
    read_at(7'd0);
    read_at(7'($urandom_range(0, 127)));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (item_q.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_q.size() != 0)
      report_mismatch("results never delivered", expected_q.size(), 0);

    $display("Checked %0d results for %0d transfers; longest line %0d of %0d chars",
             results_seen, transfers_in, peak_len, LINE_LIMIT);
    $display("Keys: %0d inserted, %0d deleted, %0d moves, %0d escape bytes, %0d ignored; %s",
             effect_hits[EFF_INSERTED], effect_hits[EFF_DELETED], effect_hits[EFF_MOVED],
             effect_hits[EFF_ESCAPE], effect_hits[EFF_IGNORED],
             (ending_key == KEY_ENTER) ? "ended by enter" : "ended by abort");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/kled_pkg.sv
hw/rtl/kled_ctrl.sv
hw/rtl/kled_dp.sv
hw/rtl/keystroke_line_edit_buffer.sv
sim/keystroke_line_edit_buffer_tb.sv
